// File: hw/rtl/tun_pkg.sv
// Shared widths and stage payload types for the triangle unit normal pipeline.
package tun_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int NORMAL_WIDTH = 16;
  localparam int FRAC_BITS    = NORMAL_WIDTH - 2;

  localparam int EDGE_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * EDGE_W;
  localparam int MAG_W  = 2 * COORD_WIDTH + 1;
  localparam int LO_W   = (MAG_W + 1) / 2;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = NORMAL_WIDTH;
  localparam int RHS_W  = SQ_W + 2 * FRAC_BITS + 2;
  localparam int TRY_W  = SUM_W + 2 * ROOT_W;
  localparam int QS_W   = SUM_W + ROOT_W;
  localparam int MAGN_W = FRAC_BITS + 1;

  typedef struct packed {
    logic                  degen;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } tun_mag_t;

  typedef struct packed {
    logic                  degen;
    logic [2:0]            neg;
    logic [SUM_W-1:0]      sum;
    logic [2:0][RHS_W-1:0] rhs;
  } tun_sq_t;

  typedef struct packed {
    logic                   degen;
    logic [2:0]             neg;
    logic [2:0][ROOT_W-1:0] root;
  } tun_root_t;

endpackage

// File: hw/rtl/triangle_unit_normal.sv
// Top level of the triangle unit normal pipeline with the rounding and output stage.
// Takes one triangle per cycle unless a stall has backed up to the input and returns
// its unit face normal, exactly rounded to nearest with ties away from zero: edges
// and cross product, then the squared length, then the normalization (each stage
// settles one quotient bit of all three components with shifts, adds and a compare)
// and one output register. Every stage holds its own valid bit, so stalls back up
// stage by stage and bubbles close up; a degenerate triangle reports zeros with the
// degenerate flag set.
module triangle_unit_normal import tun_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_WIDTH-1:0]  in_ax,
  input  logic signed [COORD_WIDTH-1:0]  in_ay,
  input  logic signed [COORD_WIDTH-1:0]  in_az,
  input  logic signed [COORD_WIDTH-1:0]  in_bx,
  input  logic signed [COORD_WIDTH-1:0]  in_by,
  input  logic signed [COORD_WIDTH-1:0]  in_bz,
  input  logic signed [COORD_WIDTH-1:0]  in_cx,
  input  logic signed [COORD_WIDTH-1:0]  in_cy,
  input  logic signed [COORD_WIDTH-1:0]  in_cz,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [NORMAL_WIDTH-1:0] out_nx,
  output logic signed [NORMAL_WIDTH-1:0] out_ny,
  output logic signed [NORMAL_WIDTH-1:0] out_nz,
  output logic                           out_degenerate
);

  localparam logic signed [NORMAL_WIDTH-1:0] UNIT = NORMAL_WIDTH'(1) << FRAC_BITS;

  logic      in_ready;
  logic      mag_valid, mag_ready;
  tun_mag_t  mag_data;
  logic      sq_valid, sq_ready;
  tun_sq_t   sq_data;
  logic      root_valid, root_ready;
  tun_root_t root_data;

  logic [ROOT_W:0]                 inc      [3];
  logic [MAGN_W-1:0]               rmag     [3];
  logic signed [NORMAL_WIDTH-1:0]  comp_nxt [3];
  logic                            out_valid_r;
  logic signed [NORMAL_WIDTH-1:0]  out_nx_r, out_ny_r, out_nz_r;
  logic                            out_degenerate_r;

  assign in_stall = !in_ready;

  tun_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pa        ({in_az, in_ay, in_ax}),
    .pb        ({in_bz, in_by, in_bx}),
    .pc        ({in_cz, in_cy, in_cx}),
    .out_valid (mag_valid),
    .out_ready (mag_ready),
    .out_data  (mag_data)
  );

  tun_square u_square (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mag_valid),
    .in_ready  (mag_ready),
    .in_data   (mag_data),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_data  (sq_data)
  );

  tun_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_data   (sq_data),
    .out_valid (root_valid),
    .out_ready (root_ready),
    .out_data  (root_data)
  );

  assign root_ready = !out_valid_r || !out_stall;

  // The quotient f is floor(2*|Nk|*2^FRAC/|N|); rounding half away is (f+1)/2.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      inc[k]  = {1'b0, root_data.root[k]} + (ROOT_W+1)'(1);
      rmag[k] = inc[k][MAGN_W:1];
      if (root_data.degen) begin
        comp_nxt[k] = '0;
      end else if (root_data.neg[k]) begin
        comp_nxt[k] = -NORMAL_WIDTH'(rmag[k]);
      end else begin
        comp_nxt[k] = NORMAL_WIDTH'(rmag[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (root_ready) begin
      out_valid_r <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (root_ready) begin
      out_nx_r         <= comp_nxt[0];
      out_ny_r         <= comp_nxt[1];
      out_nz_r         <= comp_nxt[2];
      out_degenerate_r <= root_data.degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_nx         = out_nx_r;
  assign out_ny         = out_ny_r;
  assign out_nz         = out_nz_r;
  assign out_degenerate = out_degenerate_r;

  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_degenerate_r) |-> (out_nx_r == '0 && out_ny_r == '0 && out_nz_r == '0))
    else $error("degenerate result carries a nonzero component");

  a_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_nx_r <= UNIT && out_nx_r >= -UNIT && out_ny_r <= UNIT &&
                     out_ny_r >= -UNIT && out_nz_r <= UNIT && out_nz_r >= -UNIT))
    else $error("normal component exceeds unit magnitude");

  a_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_degenerate_r) |-> (out_nx_r != '0 || out_ny_r != '0 || out_nz_r != '0))
    else $error("nondegenerate triangle produced a zero normal");

endmodule

// File: hw/rtl/tun_cross.sv
// Edge vectors, cross product and component magnitudes (three stages).
module tun_cross import tun_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0][COORD_WIDTH-1:0] pa,
  input  logic [2:0][COORD_WIDTH-1:0] pb,
  input  logic [2:0][COORD_WIDTH-1:0] pc,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tun_mag_t                    out_data
);

  logic signed [EDGE_W-1:0] u_r  [3];
  logic signed [EDGE_W-1:0] v_r  [3];
  logic signed [PROD_W-1:0] p1_r [3];
  logic signed [PROD_W-1:0] p2_r [3];
  logic signed [MAG_W:0]    dp   [3];
  logic signed [MAG_W:0]    dn   [3];
  tun_mag_t mag_nxt, mag_r;
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int k = 0; k < 3; k++) begin
        u_r[k] <= EDGE_W'($signed(pb[k])) - EDGE_W'($signed(pa[k]));
        v_r[k] <= EDGE_W'($signed(pc[k])) - EDGE_W'($signed(pa[k]));
      end
    end
    if (rdy2) begin
      p1_r[0] <= u_r[1] * v_r[2];
      p2_r[0] <= v_r[1] * u_r[2];
      p1_r[1] <= u_r[2] * v_r[0];
      p2_r[1] <= v_r[2] * u_r[0];
      p1_r[2] <= u_r[0] * v_r[1];
      p2_r[2] <= v_r[0] * u_r[1];
    end
    if (rdy3) mag_r <= mag_nxt;
  end

  // Both differences are formed so the magnitude is a selection, not a second add.
  always_comb begin
    mag_nxt.degen = 1'b1;
    for (int k = 0; k < 3; k++) begin
      dp[k] = (MAG_W+1)'(p1_r[k]) - (MAG_W+1)'(p2_r[k]);
      dn[k] = (MAG_W+1)'(p2_r[k]) - (MAG_W+1)'(p1_r[k]);
      mag_nxt.neg[k] = dp[k][MAG_W];
      mag_nxt.mag[k] = dp[k][MAG_W] ? dn[k][MAG_W-1:0] : dp[k][MAG_W-1:0];
      if (dp[k] != '0) mag_nxt.degen = 1'b0;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = mag_r;

endmodule

// File: hw/rtl/tun_square.sv
// Squared magnitudes, their sum and the scaled right-hand sides (three stages).
module tun_square import tun_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tun_mag_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tun_sq_t  out_data
);

  logic [2*HI_W-1:0] hh_r [3];
  logic [MAG_W-1:0]  hl_r [3];
  logic [2*LO_W-1:0] ll_r [3];
  logic [SQ_W-1:0]   sq_r [3];
  logic [2:0] neg4_r, neg5_r;
  logic       degen4_r, degen5_r;
  tun_sq_t    sq_nxt, out_r;
  logic v4_r, v5_r, v6_r;
  logic rdy4, rdy5, rdy6;

  assign rdy6     = !v6_r || out_ready;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign in_ready = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= in_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // The square is split into high and low halves to keep each multiplier near 32 bits.
  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int k = 0; k < 3; k++) begin
        hh_r[k] <= in_data.mag[k][MAG_W-1:LO_W] * in_data.mag[k][MAG_W-1:LO_W];
        hl_r[k] <= in_data.mag[k][MAG_W-1:LO_W] * in_data.mag[k][LO_W-1:0];
        ll_r[k] <= in_data.mag[k][LO_W-1:0] * in_data.mag[k][LO_W-1:0];
      end
      neg4_r   <= in_data.neg;
      degen4_r <= in_data.degen;
    end
    if (rdy5) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= (SQ_W'(hh_r[k]) << (2 * LO_W)) + (SQ_W'(hl_r[k]) << (LO_W + 1))
                 + SQ_W'(ll_r[k]);
      end
      neg5_r   <= neg4_r;
      degen5_r <= degen4_r;
    end
    if (rdy6) out_r <= sq_nxt;
  end

  always_comb begin
    sq_nxt.degen = degen5_r;
    sq_nxt.neg   = neg5_r;
    sq_nxt.sum   = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    for (int k = 0; k < 3; k++) begin
      sq_nxt.rhs[k] = RHS_W'(sq_r[k]) << (2 * FRAC_BITS + 2);
    end
  end

  assign out_valid = v6_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/tun_root.sv
// Bit-serial normalization: one quotient bit per stage for all three components.
module tun_root import tun_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tun_sq_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output tun_root_t out_data
);

  // Each stage finds the largest f with f*f*sum <= rhs, one bit at a time.
  // P tracks f*f*sum and Q tracks f*sum so a trial needs only shifts and adds.
  logic                   vld_r   [ROOT_W];
  logic                   rdy     [ROOT_W+1];
  logic [SUM_W-1:0]       sum_r   [ROOT_W];
  logic [2:0][RHS_W-1:0]  rhs_r   [ROOT_W];
  logic [2:0][TRY_W-1:0]  p_r     [ROOT_W];
  logic [2:0][QS_W-1:0]   q_r     [ROOT_W];
  logic [2:0][ROOT_W-1:0] f_r     [ROOT_W];
  logic [2:0]             neg_r   [ROOT_W];
  logic                   degen_r [ROOT_W];

  assign rdy[ROOT_W] = out_ready;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int B = ROOT_W - 1 - j;

    logic                   vin;
    logic                   din;
    logic [2:0]             nin;
    logic [SUM_W-1:0]       sin;
    logic [2:0][RHS_W-1:0]  xin;
    logic [2:0][TRY_W-1:0]  pin, p_nxt;
    logic [2:0][QS_W-1:0]   qin, q_nxt;
    logic [2:0][ROOT_W-1:0] fin, f_nxt;
    logic [TRY_W-1:0]       trial [3];

    if (j == 0) begin : g_head
      assign vin = in_valid;
      assign din = in_data.degen;
      assign nin = in_data.neg;
      assign sin = in_data.sum;
      assign xin = in_data.rhs;
      assign pin = '0;
      assign qin = '0;
      assign fin = '0;
    end else begin : g_body
      assign vin = vld_r[j-1];
      assign din = degen_r[j-1];
      assign nin = neg_r[j-1];
      assign sin = sum_r[j-1];
      assign xin = rhs_r[j-1];
      assign pin = p_r[j-1];
      assign qin = q_r[j-1];
      assign fin = f_r[j-1];
    end

    assign rdy[j] = !vld_r[j] || rdy[j+1];

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = pin[k] + (TRY_W'(qin[k]) << (B + 1)) + (TRY_W'(sin) << (2 * B));
        if (trial[k] <= TRY_W'(xin[k])) begin
          p_nxt[k] = trial[k];
          q_nxt[k] = qin[k] + (QS_W'(sin) << B);
          f_nxt[k] = fin[k] | (ROOT_W'(1) << B);
        end else begin
          p_nxt[k] = pin[k];
          q_nxt[k] = qin[k];
          f_nxt[k] = fin[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        vld_r[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        degen_r[j] <= din;
        neg_r[j]   <= nin;
        sum_r[j]   <= sin;
        rhs_r[j]   <= xin;
        p_r[j]     <= p_nxt;
        q_r[j]     <= q_nxt;
        f_r[j]     <= f_nxt;
      end
    end
  end

  assign in_ready       = rdy[0];
  assign out_valid      = vld_r[ROOT_W-1];
  assign out_data.degen = degen_r[ROOT_W-1];
  assign out_data.neg   = neg_r[ROOT_W-1];
  assign out_data.root  = f_r[ROOT_W-1];

endmodule

// File: tb/tb_triangle_unit_normal.sv
// Self-checking testbench for the triangle unit normal pipeline.
`timescale 1ns / 1ps

module tb_triangle_unit_normal;
  import tun_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef coord_t tri_t [9];

  typedef struct {
    logic signed [NORMAL_WIDTH-1:0] nx;
    logic signed [NORMAL_WIDTH-1:0] ny;
    logic signed [NORMAL_WIDTH-1:0] nz;
    logic                           degen;
  } normal_t;

  localparam coord_t CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  coord_t in_ax, in_ay, in_az, in_bx, in_by, in_bz, in_cx, in_cy, in_cz;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [NORMAL_WIDTH-1:0] out_nx, out_ny, out_nz;
  logic out_degenerate;

  normal_t expected_normals[$];
  int      n_errors = 0;
  int      n_checked = 0;
  int      n_degen_seen = 0;
  int      n_sent;
  bit      calm;
  int      stall_left = 0;

  triangle_unit_normal dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by(in_by), .in_bz(in_bz),
    .in_cx(in_cx), .in_cy(in_cy), .in_cz(in_cz),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_nx(out_nx), .out_ny(out_ny), .out_nz(out_nz),
    .out_degenerate(out_degenerate)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Exact normal: integer cross product, then each component rounded by a
  // bitwise search on squared quantities so no square root is needed.
  function automatic normal_t unit_normal(input tri_t p);
    logic signed [69:0] e[6];
    logic signed [69:0] n[3];
    logic signed [69:0] a;
    logic [199:0] mag[3];
    logic [199:0] sum, rhs, lhs, d;
    logic [15:0] r, t;
    logic signed [NORMAL_WIDTH-1:0] comp[3];
    normal_t res;
    for (int k = 0; k < 3; k++) begin
      e[k]   = 70'(p[3+k]) - 70'(p[k]);
      e[3+k] = 70'(p[6+k]) - 70'(p[k]);
    end
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      n[k] = e[(k+1)%3] * e[3+(k+2)%3] - e[3+(k+1)%3] * e[(k+2)%3];
      a = n[k][69] ? -n[k] : n[k];
      mag[k] = {130'b0, a};
      sum = sum + mag[k] * mag[k];
    end
    if (sum == 0) begin
      res.nx = '0; res.ny = '0; res.nz = '0; res.degen = 1'b1;
      return res;
    end
    for (int k = 0; k < 3; k++) begin
      rhs = (mag[k] * mag[k]) << (2 * FRAC_BITS + 2);
      r = '0;
      for (int b = FRAC_BITS; b >= 0; b--) begin
        t = r | (16'd1 << b);
        if (t <= (16'd1 << FRAC_BITS)) begin
          d = 200'(2 * t - 1);
          lhs = d * d * sum;
          if (lhs <= rhs) r = t;
        end
      end
      comp[k] = n[k][69] ? -$signed(r) : $signed(r);
    end
    res.nx = comp[0]; res.ny = comp[1]; res.nz = comp[2]; res.degen = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
  endtask

  task automatic queue_expected(input normal_t w);
    expected_normals.insert(expected_normals.size(), w);
  endtask

  // Compare each result transfer with the oldest outstanding normal.
  always @(posedge clk) begin
    normal_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_normals.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = expected_normals.pop_front();
        n_checked++;
        if (out_degenerate) n_degen_seen++;
        if (out_nx !== w.nx) report_mismatch("nx", out_nx, w.nx);
        if (out_ny !== w.ny) report_mismatch("ny", out_ny, w.ny);
        if (out_nz !== w.nz) report_mismatch("nz", out_nz, w.nz);
        if (out_degenerate !== w.degen) report_mismatch("degenerate", out_degenerate, w.degen);
      end
    end
  end

  // Result-side backpressure in random bursts.
  always @(negedge clk) begin
    if (calm || !rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_triangle(input tri_t p);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ax <= p[0]; in_ay <= p[1]; in_az <= p[2];
    in_bx <= p[3]; in_by <= p[4]; in_bz <= p[5];
    in_cx <= p[6]; in_cy <= p[7]; in_cz <= p[8];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    queue_expected(unit_normal(p));
    n_sent++;
    @(negedge clk);
  endtask

  function automatic tri_t make_tri(input coord_t a0, a1, a2, b0, b1, b2, c0, c1, c2);
    tri_t p;
    p = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    return p;
  endfunction

  function automatic coord_t small_coord(input int span);
    return coord_t'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic test_directed();
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(make_tri(CMAX, CMIN, 5, CMAX, CMIN, 5, CMAX, CMIN, 5));
    // Collinear points give a zero cross product.
    send_triangle(make_tri(0, 0, 0, 1, 2, 3, 2, 4, 6));
    send_triangle(make_tri(CMIN, CMIN, CMIN, 0, 0, 0, CMAX, CMAX, CMAX));
    // Axis-aligned normals, both orientations.
    send_triangle(make_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
    send_triangle(make_tri(0, 0, 0, 0, 65536, 0, 65536, 0, 0));
    send_triangle(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
    send_triangle(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0));
    send_triangle(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
    send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
    // Equal components, and two 3-4 right triangles with axis-aligned normals.
    send_triangle(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_triangle(make_tri(0, 0, 0, 4, 0, 0, 0, 3, 0));
    send_triangle(make_tri(0, 0, 0, 3, 0, 0, 0, 0, 4));
    // Full-range extremes.
    send_triangle(make_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN));
    send_triangle(make_tri(CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN));
    send_triangle(make_tri(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX));
    send_triangle(make_tri(CMAX, CMIN, 0, CMIN, 0, CMAX, 0, CMAX, CMIN));
    send_triangle(make_tri(-1, -1, -1, 0, 0, 0, 1, 0, -1));
  endtask

  task automatic test_random(input int count);
    tri_t p;
    coord_t k;
    for (int i = 0; i < count; i++) begin
      if (i == count - 200) calm = 1'b1;
      case ($urandom_range(0, 5))
        0, 1: begin
          foreach (p[j]) p[j] = coord_t'($urandom());
        end
        2: begin
          foreach (p[j]) p[j] = small_coord(8);
        end
        3: begin
          foreach (p[j]) p[j] = small_coord(70000);
        end
        4: begin
          // Collinear: C lies on the line through A and B.
          k = small_coord(3);
          for (int j = 0; j < 3; j++) begin
            p[j] = small_coord(1 << 20);
            p[3+j] = p[j] + small_coord(1 << 20);
            p[6+j] = p[j] + k * (p[3+j] - p[j]);
          end
        end
        default: begin
          // A coordinate of B copied from A, or C duplicating A.
          foreach (p[j]) p[j] = coord_t'($urandom());
          if ($urandom_range(0, 1)) p[3 + $urandom_range(0, 2)] = p[$urandom_range(0, 2)];
          else for (int j = 0; j < 3; j++) p[6+j] = p[j];
        end
      endcase
      send_triangle(p);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    n_sent = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_ax, in_ay, in_az, in_bx, in_by, in_bz, in_cx, in_cy, in_cz} = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(1850);
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Sent %0d triangles (directed extremes, random, collinear, coincident).", n_sent);
    $display("Checked %0d normals, %0d of them degenerate.", n_checked, n_degen_seen);
    if (n_errors == 0) begin
      $display("tb_triangle_unit_normal: PASS");
    end else begin
      $display("tb_triangle_unit_normal: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_triangle_unit_normal: FAIL");
    $finish;
  end

endmodule
